[sv/shwa_pkg.sv]
// Shared constants, types and helpers for the sensor hit to world area check block.
`default_nettype none
package shwa_pkg;
   localparam int COORD_BITS   = 16;
   localparam int ANGLE_BITS   = 16;
   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_XW    = 34;   // Q2.30 plus guard
   localparam int CORDIC_ZW    = 33;
   localparam int TRIG_W       = 17;   // Q1.15 with room for negation
   localparam int PROD_W       = COORD_BITS + TRIG_W;
   localparam int SUM_W        = PROD_W + 3;
   // fold register, one register per iteration, round/quadrant register
   localparam int CORDIC_LAT   = CORDIC_STEPS + 2;

   localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;
   localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN = CORDIC_XW'(652032874);

   localparam logic [31:0] ATAN_TABLE [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_MOUNT_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MOUNT_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MOUNT_A  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_AREA_E   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_AREA_W   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_AREA_N   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_AREA_S   = 3'd6;

   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef struct packed {
      logic signed [COORD_BITS-1:0] rx;
      logic signed [COORD_BITS-1:0] ry;
      logic signed [COORD_BITS-1:0] rng;
   } payload_type;

   // Round a Q15 coordinate to nearest (ties up) and saturate.
   function automatic logic signed [COORD_BITS-1:0] round_coord(
      input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] t;
      logic signed [SUM_W-16:0] q;
      begin
         t = v + SUM_W'(16384);
         q = t[SUM_W-1:15];
         if (q > (SUM_W-15)'(COORD_MAX))
            round_coord = COORD_MAX;
         else if (q < (SUM_W-15)'(COORD_MIN))
            round_coord = COORD_MIN;
         else
            round_coord = q[COORD_BITS-1:0];
      end
   endfunction
endpackage
`default_nettype wire

[sv/shwa_cordic.sv]
// Pipelined rotation-mode CORDIC: Q1.15 cosine and sine of a 32-bit turn angle.
`default_nettype none
module shwa_cordic (
   input  wire logic                                clock,
   input  wire logic                                en,
   input  wire logic [31:0]                         ang_in,
   output logic signed [shwa_pkg::TRIG_W-1:0]       cos_out,
   output logic signed [shwa_pkg::TRIG_W-1:0]       sin_out
);
   import shwa_pkg::*;

   logic signed [CORDIC_XW-1:0] x_ff [CORDIC_STEPS+1];
   logic signed [CORDIC_XW-1:0] y_ff [CORDIC_STEPS+1];
   logic signed [CORDIC_ZW-1:0] z_ff [CORDIC_STEPS+1];
   logic [1:0]                  quad_ff [CORDIC_STEPS+1];

   logic [31:0]                 shifted;
   logic signed [CORDIC_ZW-1:0] z_in;
   logic signed [CORDIC_XW:0]   xr_sum, yr_sum;
   logic signed [CORDIC_XW-15:0] xr_q, yr_q;
   logic signed [TRIG_W-1:0]    c_sat, s_sat, cos_in, sin_in;
   logic signed [TRIG_W-1:0]    cos_ff, sin_ff;

   // fold into [-1/8, 1/8) turn plus quadrant
   assign shifted = ang_in + EIGHTH_TURN;
   assign z_in = $signed({3'b000, shifted[29:0]}) - $signed({3'b000, EIGHTH_TURN[29:0]});

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= z_in;
         quad_ff[0] <= shifted[31:30];
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [CORDIC_XW-1:0] dx, dy;
      logic signed [CORDIC_ZW-1:0] at;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      assign at = $signed({1'b0, ATAN_TABLE[i]});
      always_ff @(posedge clock) begin
         if (en) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - at;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + at;
            end
            quad_ff[i+1] <= quad_ff[i];
         end
      end
   end

   assign xr_sum = (CORDIC_XW+1)'(x_ff[CORDIC_STEPS]) + (CORDIC_XW+1)'(16384);
   assign yr_sum = (CORDIC_XW+1)'(y_ff[CORDIC_STEPS]) + (CORDIC_XW+1)'(16384);
   assign xr_q = xr_sum[CORDIC_XW:15];
   assign yr_q = yr_sum[CORDIC_XW:15];

   always_comb begin
      if (xr_q > (CORDIC_XW-14)'(32767))       c_sat = TRIG_W'(32767);
      else if (xr_q < -(CORDIC_XW-14)'(32768)) c_sat = -TRIG_W'(32768);
      else                                     c_sat = xr_q[TRIG_W-1:0];
      if (yr_q > (CORDIC_XW-14)'(32767))       s_sat = TRIG_W'(32767);
      else if (yr_q < -(CORDIC_XW-14)'(32768)) s_sat = -TRIG_W'(32768);
      else                                     s_sat = yr_q[TRIG_W-1:0];
      unique case (quad_ff[CORDIC_STEPS])
         2'd0: begin cos_in = c_sat;  sin_in = s_sat;  end
         2'd1: begin cos_in = -s_sat; sin_in = c_sat;  end
         2'd2: begin cos_in = -c_sat; sin_in = -s_sat; end
         default: begin cos_in = s_sat; sin_in = -c_sat; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;
endmodule
`default_nettype wire

[sv/sensor_hit_to_world_area_check_top.sv]
// Top level: pose plus range reading to sensor and object world positions with area test.
// One beat in per clock when not held and one result beat out per input beat; the beat
// passes two 24-iteration CORDIC pipelines running side by side, then product, pose sum,
// round/saturate and area compare stages. The whole pipeline advances together
// and holds while a result waits on rsp_ready. Configuration writes take effect at once
// and belong in idle periods.
`default_nettype none
module sensor_hit_to_world_area_check_top (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [shwa_pkg::COORD_BITS-1:0] req_robot_x,
   input  wire logic signed [shwa_pkg::COORD_BITS-1:0] req_robot_y,
   input  wire logic [shwa_pkg::ANGLE_BITS-1:0]        req_robot_heading,
   input  wire logic signed [shwa_pkg::COORD_BITS-1:0] req_range_reading,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [shwa_pkg::COORD_BITS-1:0]      rsp_sensor_world_x,
   output logic signed [shwa_pkg::COORD_BITS-1:0]      rsp_sensor_world_y,
   output logic signed [shwa_pkg::COORD_BITS-1:0]      rsp_object_world_x,
   output logic signed [shwa_pkg::COORD_BITS-1:0]      rsp_object_world_y,
   output logic                                        rsp_reading_valid,
   output logic                                        rsp_object_in_area,
   input  wire logic                                   csr_wr_en,
   input  wire logic [shwa_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [shwa_pkg::COORD_BITS-1:0]        csr_wr_data
);
   import shwa_pkg::*;

   logic signed [COORD_BITS-1:0] mount_x_ff, mount_y_ff;
   logic [ANGLE_BITS-1:0]        mount_a_ff;
   logic signed [COORD_BITS-1:0] east_ff, west_ff, north_ff, south_ff;

   logic en;
   logic [ANGLE_BITS-1:0] ang_sum;
   logic signed [TRIG_W-1:0] ch, sh, cb, sb;

   logic        vld_ff [CORDIC_LAT];
   payload_type pl_ff  [CORDIC_LAT];
   payload_type pl_in;

   // product stage
   logic vm_ff;
   payload_type pm_ff;
   logic signed [PROD_W-1:0] p_xc_ff, p_ys_ff, p_xs_ff, p_yc_ff, p_dc_ff, p_ds_ff;
   // pose sum stage
   logic va_ff;
   logic signed [COORD_BITS-1:0] rng_a_ff;
   logic signed [SUM_W-1:0] base_x_ff, base_y_ff, dc_a_ff, ds_a_ff;
   logic signed [SUM_W-1:0] base_x_in, base_y_in;
   // round stage
   logic vb_ff, rv_b_ff;
   logic signed [COORD_BITS-1:0] sx_b_ff, sy_b_ff, ox_b_ff, oy_b_ff;
   logic signed [COORD_BITS-1:0] ox_b_in, oy_b_in;
   // output register
   logic out_valid_ff, in_area_ff, rv_ff;
   logic signed [COORD_BITS-1:0] sx_ff, sy_ff, ox_ff, oy_ff;
   logic in_area_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mount_x_ff <= '0;
         mount_y_ff <= '0;
         mount_a_ff <= '0;
         east_ff    <= COORD_MAX;
         west_ff    <= COORD_MIN;
         north_ff   <= COORD_MAX;
         south_ff   <= COORD_MIN;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_MOUNT_X: mount_x_ff <= csr_wr_data;
            REG_MOUNT_Y: mount_y_ff <= csr_wr_data;
            REG_MOUNT_A: mount_a_ff <= csr_wr_data[ANGLE_BITS-1:0];
            REG_AREA_E:  east_ff    <= csr_wr_data;
            REG_AREA_W:  west_ff    <= csr_wr_data;
            REG_AREA_N:  north_ff   <= csr_wr_data;
            REG_AREA_S:  south_ff   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign en        = !out_valid_ff || rsp_ready;
   assign req_ready = en;
   assign ang_sum   = mount_a_ff + req_robot_heading;

   shwa_cordic u_cordic_head (
      .clock   (clock),
      .en      (en),
      .ang_in  ({req_robot_heading, {(32-ANGLE_BITS){1'b0}}}),
      .cos_out (ch),
      .sin_out (sh)
   );

   shwa_cordic u_cordic_beam (
      .clock   (clock),
      .en      (en),
      .ang_in  ({ang_sum, {(32-ANGLE_BITS){1'b0}}}),
      .cos_out (cb),
      .sin_out (sb)
   );

   assign pl_in = '{rx: req_robot_x, ry: req_robot_y, rng: req_range_reading};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CORDIC_LAT; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < CORDIC_LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pl_ff[0] <= pl_in;
         for (int i = 1; i < CORDIC_LAT; i++) pl_ff[i] <= pl_ff[i-1];
      end
   end

   // products
   always_ff @(posedge clock) begin
      if (en) begin
         pm_ff   <= pl_ff[CORDIC_LAT-1];
         p_xc_ff <= PROD_W'(mount_x_ff) * PROD_W'(ch);
         p_ys_ff <= PROD_W'(mount_y_ff) * PROD_W'(sh);
         p_xs_ff <= PROD_W'(mount_x_ff) * PROD_W'(sh);
         p_yc_ff <= PROD_W'(mount_y_ff) * PROD_W'(ch);
         p_dc_ff <= PROD_W'(pl_ff[CORDIC_LAT-1].rng) * PROD_W'(cb);
         p_ds_ff <= PROD_W'(pl_ff[CORDIC_LAT-1].rng) * PROD_W'(sb);
      end
   end

   assign base_x_in = (SUM_W'(pm_ff.rx) <<< 15) + SUM_W'(p_xc_ff) - SUM_W'(p_ys_ff);
   assign base_y_in = (SUM_W'(pm_ff.ry) <<< 15) + SUM_W'(p_xs_ff) + SUM_W'(p_yc_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         base_x_ff <= base_x_in;
         base_y_ff <= base_y_in;
         dc_a_ff   <= SUM_W'(p_dc_ff);
         ds_a_ff   <= SUM_W'(p_ds_ff);
         rng_a_ff  <= pm_ff.rng;
      end
   end

   assign ox_b_in = round_coord(base_x_ff + dc_a_ff);
   assign oy_b_in = round_coord(base_y_ff + ds_a_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         sx_b_ff <= round_coord(base_x_ff);
         sy_b_ff <= round_coord(base_y_ff);
         rv_b_ff <= !rng_a_ff[COORD_BITS-1];
         // negative range: object fields forced to zero
         ox_b_ff <= rng_a_ff[COORD_BITS-1] ? '0 : ox_b_in;
         oy_b_ff <= rng_a_ff[COORD_BITS-1] ? '0 : oy_b_in;
      end
   end

   assign in_area_in = rv_b_ff && (ox_b_ff <= east_ff) && (ox_b_ff >= west_ff) &&
                       (oy_b_ff <= north_ff) && (oy_b_ff >= south_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         sx_ff      <= sx_b_ff;
         sy_ff      <= sy_b_ff;
         ox_ff      <= ox_b_ff;
         oy_ff      <= oy_b_ff;
         rv_ff      <= rv_b_ff;
         in_area_ff <= in_area_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff        <= 1'b0;
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         vm_ff        <= vld_ff[CORDIC_LAT-1];
         va_ff        <= vm_ff;
         vb_ff        <= va_ff;
         out_valid_ff <= vb_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_sensor_world_x = sx_ff;
   assign rsp_sensor_world_y = sy_ff;
   assign rsp_object_world_x = ox_ff;
   assign rsp_object_world_y = oy_ff;
   assign rsp_reading_valid  = rv_ff;
   assign rsp_object_in_area = in_area_ff;
endmodule
`default_nettype wire
